FILE: src/lhr_pkg.sv
// Shared types, codes and helpers for the link handshake retry core.
package lhr_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned RetryW = 4;
  localparam int unsigned IdW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [RetryW-1:0] RetryMax = {RetryW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_OWN_ID          = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HANDSHAKE_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ACK_TICKS       = 2'd3;

  localparam logic [IdW-1:0]    OWN_ID_RST          = 8'hA2;
  localparam logic [RetryW-1:0] RETRY_LIMIT_RST     = 4'd3;
  localparam logic [TimerW-1:0] HANDSHAKE_TICKS_RST = 16'd1000;
  localparam logic [TimerW-1:0] ACK_TICKS_RST       = 16'd1000;

  // Event kinds.
  localparam logic [1:0] REQ_PKT  = 2'd0;
  localparam logic [1:0] REQ_HOST = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Received packet kinds.
  localparam logic [2:0] KIND_SYN  = 3'd0;
  localparam logic [2:0] KIND_ACK  = 3'd2;
  localparam logic [2:0] KIND_DATA = 3'd3;
  localparam logic [2:0] KIND_DACK = 3'd4;

  // Packets to send.
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_SYN_ACK  = 3'd1;
  localparam logic [2:0] SEND_DATA_ACK = 3'd2;
  localparam logic [2:0] SEND_NEW      = 3'd3;
  localparam logic [2:0] SEND_RESEND   = 3'd4;

  // Reported phase codes.
  localparam logic [1:0] CODE_LISTEN    = 2'd0;
  localparam logic [1:0] CODE_WAIT_ACK  = 2'd1;
  localparam logic [1:0] CODE_CONNECTED = 2'd2;
  localparam logic [1:0] CODE_WAIT_DACK = 2'd3;

  typedef enum logic [3:0] {
    PH_LISTEN    = 4'b0001,
    PH_WAIT_ACK  = 4'b0010,
    PH_CONNECTED = 4'b0100,
    PH_WAIT_DACK = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [IdW-1:0]    own_id;
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] handshake_ticks;
    logic [TimerW-1:0] ack_ticks;
  } cfg_regs_t;

  typedef struct packed {
    phase_t            phase;
    logic [RetryW-1:0] retries;
    logic [TimerW-1:0] timer;
  } link_state_t;

  typedef struct packed {
    logic [2:0] send_kind;
    logic       deliver_payload;
    logic       host_data_taken;
    logic [1:0] link_phase;
    logic       connected_event;
    logic       gave_up_event;
  } step_result_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_WAIT_ACK:  code = CODE_WAIT_ACK;
      PH_CONNECTED: code = CODE_CONNECTED;
      PH_WAIT_DACK: code = CODE_WAIT_DACK;
      default:      code = CODE_LISTEN;
    endcase
    return code;
  endfunction

endpackage

FILE: src/link_handshake_retry_fsm_core.sv
// Top level of the link handshake responder with data retransmission.
//
//   Channel  Direction  Ports                                   Word
//   in_      input      in_valid, in_ready, in_req_type ...     one link event
//   out_     output     out_valid, out_ready, out_send_kind ... one result
//   cfg_     input      cfg_valid, cfg_ready, cfg_index ...     one register write
//
// Each event is registered, then the link state and result are computed and registered
// together; a new event can enter while the last is computed unless the output stalls.
// The link state itself updates in the same cycle the result is captured.
// A stalled output holds its word while one further event waits in the input stage.
// Reset clears the link state, the handshake flags and the registers to defaults.
module link_handshake_retry_fsm_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_req_type,
  input  logic [2:0]                   in_pkt_kind,
  input  logic [7:0]                   in_dest_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_send_kind,
  output logic                         out_deliver_payload,
  output logic                         out_host_data_taken,
  output logic [1:0]                   out_link_phase,
  output logic                         out_connected_event,
  output logic                         out_gave_up_event,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lhr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lhr_pkg::CfgDataW-1:0] cfg_wdata
);
  import lhr_pkg::*;

  cfg_regs_t    cfg_r;
  link_state_t  state_r;
  link_state_t  state_nxt;
  step_result_t res_nxt;
  step_result_t res_r;

  logic       s1_valid_r;
  logic [1:0] s1_req_r;
  logic [2:0] s1_kind_r;
  logic [7:0] s1_dest_r;
  logic       out_valid_r;
  logic       advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id          <= OWN_ID_RST;
      cfg_r.retry_limit     <= RETRY_LIMIT_RST;
      cfg_r.handshake_ticks <= HANDSHAKE_TICKS_RST;
      cfg_r.ack_ticks       <= ACK_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_ID:          cfg_r.own_id          <= cfg_wdata[IdW-1:0];
        REG_RETRY_LIMIT:     cfg_r.retry_limit     <= cfg_wdata[RetryW-1:0];
        REG_HANDSHAKE_TICKS: cfg_r.handshake_ticks <= cfg_wdata[TimerW-1:0];
        REG_ACK_TICKS:       cfg_r.ack_ticks       <= cfg_wdata[TimerW-1:0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_kind_r <= in_pkt_kind;
      s1_dest_r <= in_dest_id;
    end
  end

  lhr_step u_step (
    .cfg      (cfg_r),
    .cur      (state_r),
    .req_type (s1_req_r),
    .pkt_kind (s1_kind_r),
    .dest_id  (s1_dest_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_LISTEN;
      state_r.retries <= '0;
      state_r.timer   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_send_kind       = res_r.send_kind;
  assign out_deliver_payload = res_r.deliver_payload;
  assign out_host_data_taken = res_r.host_data_taken;
  assign out_link_phase      = res_r.link_phase;
  assign out_connected_event = res_r.connected_event;
  assign out_gave_up_event   = res_r.gave_up_event;

endmodule

FILE: src/lhr_step.sv
// Next-state and result logic for one link event.
module lhr_step (
  input  lhr_pkg::cfg_regs_t    cfg,
  input  lhr_pkg::link_state_t  cur,
  input  logic [1:0]            req_type,
  input  logic [2:0]            pkt_kind,
  input  logic [7:0]            dest_id,
  output lhr_pkg::link_state_t  nxt,
  output lhr_pkg::step_result_t res
);
  import lhr_pkg::*;

  logic [TimerW-1:0] timer_inc;
  logic [RetryW-1:0] retries_inc;
  logic              wait_phase;

  assign wait_phase  = (cur.phase == PH_WAIT_ACK) || (cur.phase == PH_WAIT_DACK);
  assign timer_inc   = (cur.timer == TimerMax) ? cur.timer : cur.timer + TimerW'(1);
  assign retries_inc = (cur.retries == RetryMax) ? cur.retries : cur.retries + RetryW'(1);

  always_comb begin
    nxt = cur;
    res = '0;
    case (req_type)
      REQ_PKT: begin
        nxt.timer = '0;
        if (pkt_kind == KIND_SYN) begin
          res.send_kind = SEND_SYN_ACK;
          nxt.phase     = PH_WAIT_ACK;
        end else if (cur.phase == PH_WAIT_ACK) begin
          if (pkt_kind == KIND_ACK) begin
            nxt.phase           = PH_CONNECTED;
            nxt.retries         = '0;
            res.connected_event = 1'b1;
          end
        end else if (cur.phase == PH_CONNECTED || cur.phase == PH_WAIT_DACK) begin
          if (pkt_kind == KIND_DATA) begin
            if (dest_id == cfg.own_id) begin
              res.deliver_payload = 1'b1;
              res.send_kind       = SEND_DATA_ACK;
            end
          end else if (pkt_kind == KIND_DACK && cur.phase == PH_WAIT_DACK) begin
            nxt.phase   = PH_CONNECTED;
            nxt.retries = '0;
          end
        end
      end
      REQ_HOST: begin
        if (cur.phase == PH_CONNECTED) begin
          res.send_kind       = SEND_NEW;
          res.host_data_taken = 1'b1;
          nxt.phase           = PH_WAIT_DACK;
          nxt.retries         = '0;
          nxt.timer           = '0;
        end
      end
      REQ_TICK: begin
        if (wait_phase) begin
          nxt.timer = timer_inc;
          if (cur.phase == PH_WAIT_ACK) begin
            if (timer_inc >= cfg.handshake_ticks) begin
              nxt.phase         = PH_LISTEN;
              nxt.timer         = '0;
              res.gave_up_event = 1'b1;
            end
          end else if (timer_inc >= cfg.ack_ticks) begin
            nxt.timer = '0;
            if (retries_inc >= cfg.retry_limit) begin
              nxt.phase         = PH_LISTEN;
              nxt.retries       = '0;
              res.gave_up_event = 1'b1;
            end else begin
              nxt.retries   = retries_inc;
              res.send_kind = SEND_RESEND;
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.link_phase = phase_code(nxt.phase);
  end

endmodule

FILE: src/lhr_checker.sv
// Port-level checks for the link handshake core, bound to the top level.
module lhr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_send_kind,
  input logic       out_deliver_payload,
  input logic       out_host_data_taken,
  input logic [1:0] out_link_phase,
  input logic       out_connected_event,
  input logic       out_gave_up_event
);
  import lhr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_kind)
      && $stable(out_link_phase))
    else $error("Output word changed while stalled.");

  a_gave_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gave_up_event |-> out_link_phase == CODE_LISTEN
      && !out_connected_event)
    else $error("Give-up reported outside the listening phase.");

  a_connect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_connected_event |-> out_link_phase == CODE_CONNECTED
      && out_send_kind == SEND_NONE)
    else $error("Connect event with wrong phase or packet.");

  a_host: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_host_data_taken |-> out_send_kind == SEND_NEW
      && out_link_phase == CODE_WAIT_DACK)
    else $error("Host data taken without a new data send.");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver_payload |-> out_send_kind == SEND_DATA_ACK)
    else $error("Payload delivered without a data acknowledge.");

endmodule

bind link_handshake_retry_fsm_core lhr_checker u_lhr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_send_kind       (out_send_kind),
  .out_deliver_payload (out_deliver_payload),
  .out_host_data_taken (out_host_data_taken),
  .out_link_phase      (out_link_phase),
  .out_connected_event (out_connected_event),
  .out_gave_up_event   (out_gave_up_event)
);
